// ----- rtl/cuckoo_hash_insert_assert.svh -----
// assertion macros used by the checker file of the cuckoo insert block
`ifndef CUCKOO_HASH_INSERT_ASSERT_SVH
`define CUCKOO_HASH_INSERT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CHI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cuckoo insert check failed");

// consequent must hold in the cycle after the antecedent
`define CHI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cuckoo insert check failed");

`endif

// ----- rtl/chi_pkg.sv -----
`default_nettype none

package chi_pkg;

  // field widths
  localparam int KEY_W      = 31;
  localparam int KICKS_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int TS_W       = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  // largest modulus the size register can express
  localparam int TS_MAX = 31;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_KICKED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAIL   = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_KICKS  = 1'd1;

endpackage

`default_nettype wire

// ----- rtl/chi_ram.sv -----
`default_nettype none

module chi_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/cuckoo_hash_insert.sv -----
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: key
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: kicks, homeless_key; tuser: status
// cfg       in         cfg_we_i                     cfg_addr_i, cfg_wdata_i
//
// one item at a time; the shared bit-serial divider sets the pace: key mod m for a
// table-one hash, key div m, then mod m for a table-two hash
// an insert runs divide and check, then swap, divide and check per eviction, and
// ends in a done state that hands the result to the output register
// reset clears the valid marks and loads table_size 16, max_kicks 16
// a stalled output holds one result; the next item is accepted meanwhile
`default_nettype none

module cuckoo_hash_insert #(
  parameter int DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // key
  input  wire logic [chi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // kicks [7:0], homeless_key [38:8], zero [39]
  output logic [chi_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // status [1:0]
  output logic [chi_pkg::STATUS_W-1:0]             m_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_we_i,
  input  wire logic [chi_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire logic [chi_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  // only slots below the largest usable modulus are ever addressed
  localparam int SLOTS  = (DEPTH < chi_pkg::TS_MAX) ? DEPTH : chi_pkg::TS_MAX;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W  = chi_pkg::KEY_W;
  localparam int TS_W   = chi_pkg::TS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SWAP  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                     state_q, state_d;
  logic [TS_W-1:0]                table_size_q;
  logic [chi_pkg::KICKS_W-1:0]    max_kicks_q;
  logic [KEY_W-1:0]               cur_q, cur_d;
  logic [KEY_W-1:0]               dvd_q, dvd_d;
  logic [TS_W-1:0]                rem_q, rem_d;
  logic [TS_W-1:0]                step_q, step_d;
  logic                           pass_q, pass_d;
  logic                           which_q, which_d;
  logic [chi_pkg::KICKS_W-1:0]    kicks_q, kicks_d;
  logic [TS_W-1:0]                m_q, m_d;
  logic [SLOT_W-1:0]              slot_q, slot_d;
  logic [chi_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic [SLOTS-1:0]               valid1_q, valid1_d;
  logic [SLOTS-1:0]               valid2_q, valid2_d;
  logic                           out_valid_q, out_valid_d;
  logic [chi_pkg::STATUS_W-1:0]   out_status_q;
  logic [chi_pkg::KICKS_W-1:0]    out_kicks_q;
  logic [KEY_W-1:0]               out_key_q;
  logic                           out_load;

  logic [TS_W-1:0]  eff_size;
  logic [TS_W:0]    rem_sh;
  logic             rem_ge;
  logic [TS_W-1:0]  rem_nx;
  logic [KEY_W-1:0] quo_nx;
  logic             occupied;
  logic             in_accept;

  logic             we1, we2, re1, re2;
  logic [KEY_W-1:0] rdata1, rdata2, evicted;

  // effective modulus: zero acts as one, large sizes saturate
  always_comb begin
    if (table_size_q == '0) begin
      eff_size = TS_W'(1);
    end else if (int'(table_size_q) > SLOTS) begin
      eff_size = TS_W'(SLOTS);
    end else begin
      eff_size = table_size_q;
    end
  end

  // shared restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q, dvd_q[KEY_W-1]};
  assign rem_ge = rem_sh >= {1'b0, m_q};
  assign rem_nx = rem_ge ? TS_W'(rem_sh - {1'b0, m_q}) : rem_sh[TS_W-1:0];
  assign quo_nx = {dvd_q[KEY_W-2:0], rem_ge};

  assign occupied  = which_q ? valid2_q[slot_q] : valid1_q[slot_q];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign evicted   = which_q ? rdata2 : rdata1;

  // key stores of the two tables
  assign we1 = !which_q && (((state_q == S_CHECK) && !occupied) || (state_q == S_SWAP));
  assign we2 = which_q && (((state_q == S_CHECK) && !occupied) || (state_q == S_SWAP));
  assign re1 = !which_q && (state_q == S_CHECK) && occupied && (kicks_q < max_kicks_q);
  assign re2 = which_q && (state_q == S_CHECK) && occupied && (kicks_q < max_kicks_q);

  chi_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_first_keys (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (slot_q),
    .wdata_i (cur_q),
    .re_i    (re1),
    .raddr_i (slot_q),
    .rdata_o (rdata1)
  );

  chi_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_second_keys (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (slot_q),
    .wdata_i (cur_q),
    .re_i    (re2),
    .raddr_i (slot_q),
    .rdata_o (rdata2)
  );

  // insert sequencer
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    step_d       = step_q;
    pass_d       = pass_q;
    which_d      = which_q;
    kicks_d      = kicks_q;
    m_d          = m_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    valid1_d     = valid1_q;
    valid2_d     = valid2_q;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cur_d   = s_axis_tdata[KEY_W-1:0];
          dvd_d   = s_axis_tdata[KEY_W-1:0];
          rem_d   = '0;
          step_d  = '0;
          pass_d  = 1'b0;
          which_d = 1'b0;
          kicks_d = '0;
          m_d     = eff_size;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        dvd_d  = quo_nx;
        rem_d  = rem_nx;
        step_d = step_q + TS_W'(1);
        if (step_q == TS_W'(KEY_W - 1)) begin
          if (which_q && !pass_q) begin
            // second pass: quotient mod m
            rem_d  = '0;
            step_d = '0;
            pass_d = 1'b1;
          end else begin
            slot_d  = rem_nx[SLOT_W-1:0];
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!occupied) begin
          if (which_q) begin
            valid2_d[slot_q] = 1'b1;
          end else begin
            valid1_d[slot_q] = 1'b1;
          end
          res_status_d = (kicks_q == '0) ? chi_pkg::ST_EMPTY : chi_pkg::ST_KICKED;
          state_d      = S_DONE;
        end else if (kicks_q >= max_kicks_q) begin
          res_status_d = chi_pkg::ST_FAIL;
          state_d      = S_DONE;
        end else begin
          state_d = S_SWAP;
        end
      end
      S_SWAP: begin
        // new key went into the slot, occupant moves to the other table
        cur_d   = evicted;
        dvd_d   = evicted;
        rem_d   = '0;
        step_d  = '0;
        pass_d  = 1'b0;
        which_d = !which_q;
        kicks_d = kicks_q + chi_pkg::KICKS_W'(1);
        state_d = S_DIV;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      pass_q       <= 1'b0;
      which_q      <= 1'b0;
      kicks_q      <= '0;
      valid1_q     <= '0;
      valid2_q     <= '0;
      out_valid_q  <= 1'b0;
      table_size_q <= TS_W'(16);
      max_kicks_q  <= chi_pkg::KICKS_W'(16);
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      which_q     <= which_d;
      kicks_q     <= kicks_d;
      valid1_q    <= valid1_d;
      valid2_q    <= valid2_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          chi_pkg::CFG_TABLE_SIZE: table_size_q <= cfg_wdata_i[TS_W-1:0];
          chi_pkg::CFG_MAX_KICKS:  max_kicks_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    m_q          <= m_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_kicks_q  <= kicks_q;
      out_key_q    <= (res_status_q == chi_pkg::ST_FAIL) ? cur_q : '0;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_key_q, out_kicks_q};

endmodule

`default_nettype wire

// ----- rtl/chi_checker.sv -----
`default_nettype none

`include "cuckoo_hash_insert_assert.svh"

module chi_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [chi_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic [chi_pkg::STATUS_W-1:0]    m_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready
);

  logic                          in_acc;
  logic [chi_pkg::KICKS_W-1:0]   out_kicks;
  logic [chi_pkg::KEY_W-1:0]     out_key;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_kicks = m_axis_tdata[chi_pkg::KICKS_W-1:0];
  assign out_key   = m_axis_tdata[chi_pkg::KICKS_W +: chi_pkg::KEY_W];

  // an insert always needs the divider, so no item follows directly
  `CHI_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready)

  // only failures report a dropped key
  `CHI_ASSERT_NOW(a_key_only_on_fail, clk_i, rst_ni,
                  m_axis_tvalid && (m_axis_tuser != chi_pkg::ST_FAIL), out_key == '0)

  // placed status agrees with the eviction count
  `CHI_ASSERT_NOW(a_status_vs_kicks, clk_i, rst_ni,
                  m_axis_tvalid && (m_axis_tuser != chi_pkg::ST_FAIL),
                  (m_axis_tuser == chi_pkg::ST_EMPTY) == (out_kicks == '0))

  // a stalled result holds
  `CHI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind cuckoo_hash_insert chi_checker u_chi_checker (.*);

`default_nettype wire
